/* rtl/r2k_pkg.sv */
// Package for the romaji-to-kana converter: widths, key codes and the
// reversed-romaji match function. No dependencies.
package r2k_pkg;

  localparam int HISTORY_DEPTH = 5;
  localparam int TABLE_SIZE    = 280;
  localparam logic [8:0] KEY_CLEAR = 9'h000;
  localparam logic [8:0] KEY_OFF   = 9'h1FF;
  localparam logic [8:0] KEY_TAB   = 9'h009;
  localparam logic [7:0] CHAR_N    = 8'h6E;

  typedef logic [7:0] char_t;
  typedef char_t [HISTORY_DEPTH-1:0] hist_t;

  typedef struct packed {
    logic       matched;
    logic [2:0] erase_count;
    logic       prefix_n;
    logic       prefix_small_tsu;
    logic [8:0] kana_index;
  } result_t;

  typedef struct packed {
    logic       hit;
    logic [1:0] len;
    logic [8:0] idx;
  } match_t;

  function automatic char_t fold(input char_t c);
    fold = (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
  endfunction

  // Priority match of the newest keys against the table, folded letters.
  // Table order: 3-letter entries (idx 0..124), 2-letter (125..231),
  // single keys (232..279).
  function automatic match_t find_entry(input hist_t h);
    char_t c0, c1, c2;
    logic [8:0] idx;
    logic hit;
    logic [1:0] len;
    logic [2:0] v0, v2;
    logic [4:0] cons;
    hit = 1'b0; len = 2'd0; idx = 9'd0;
    c0 = fold(h[0]); c1 = fold(h[1]); c2 = fold(h[2]);
    v0 = 3'd7; v2 = 3'd7; cons = 5'd31;
    case (c0)
      "a": v0 = 3'd0; "i": v0 = 3'd1; "u": v0 = 3'd2;
      "e": v0 = 3'd3; "o": v0 = 3'd4; default: v0 = 3'd7;
    endcase
    // three-letter entries: vowel, y/h/s, consonant
    if (v0 != 3'd7 && c1 == "y") begin
      case (c2)
        "b": cons = 5'd0;  "c": cons = 5'd1;  "d": cons = 5'd2;  "f": cons = 5'd3;
        "g": cons = 5'd4;  "h": cons = 5'd5;  "j": cons = 5'd6;  "k": cons = 5'd7;
        "m": cons = 5'd8;  "n": cons = 5'd9;  "p": cons = 5'd10; "q": cons = 5'd11;
        "r": cons = 5'd12; "s": cons = 5'd13; "t": cons = 5'd14; "v": cons = 5'd15;
        "x": cons = 5'd16; "z": cons = 5'd17; default: cons = 5'd31;
      endcase
    end else if (v0 != 3'd7 && c1 == "h") begin
      case (c2)
        "c": cons = 5'd18; "d": cons = 5'd19; "p": cons = 5'd20;
        "s": cons = 5'd21; "t": cons = 5'd22; "w": cons = 5'd23;
        default: cons = 5'd31;
      endcase
    end else if (v0 != 3'd7 && c1 == "s" && c2 == "t") begin
      cons = 5'd24;
    end
    if (cons != 5'd31) begin
      hit = 1'b1; len = 2'd3;
      idx = 9'(cons) * 9'd5 + 9'(v0);
    end else begin
      if (v0 != 3'd7) begin
        case (c1)
          "b": cons = 5'd0;  "c": cons = 5'd1;  "d": cons = 5'd2;  "f": cons = 5'd3;
          "g": cons = 5'd4;  "h": cons = 5'd5;  "j": cons = 5'd6;  "k": cons = 5'd7;
          "l": cons = 5'd8;  "m": cons = 5'd9;  "n": cons = 5'd10; "p": cons = 5'd11;
          "q": cons = 5'd12; "r": cons = 5'd13; "s": cons = 5'd14; "t": cons = 5'd15;
          "v": cons = 5'd16; "w": cons = 5'd17; "x": cons = 5'd18; "y": cons = 5'd19;
          "z": cons = 5'd20; default: cons = 5'd31;
        endcase
      end
      if (cons != 5'd31) begin
        hit = 1'b1; len = 2'd2;
        // "nn" sits after the "n" group, shifting later groups by one
        idx = 9'd125 + 9'(cons) * 9'd5 + 9'(v0) + ((cons > 5'd10) ? 9'd1 : 9'd0);
      end else if (c0 == "n" && c1 == "n") begin
        hit = 1'b1; len = 2'd2; idx = 9'd180;
      end else if (c0 == "'" && c1 == "n") begin
        hit = 1'b1; len = 2'd2; idx = 9'd231;
      end else if (v0 != 3'd7) begin
        hit = 1'b1; len = 2'd1; idx = 9'd232 + 9'(v0);
      end else if (c0 >= 8'h20 && c0 <= 8'h40) begin
        hit = 1'b1; len = 2'd1; idx = 9'd237 + 9'(c0 - 8'h20);
      end else if (c0 >= 8'h5B && c0 <= 8'h60) begin
        hit = 1'b1; len = 2'd1; idx = 9'd270 + 9'(c0 - 8'h5B);
      end else if (c0 >= 8'h7B && c0 <= 8'h7E) begin
        hit = 1'b1; len = 2'd1; idx = 9'd276 + 9'(c0 - 8'h7B);
      end
    end
    find_entry = {hit, len, idx};
  endfunction

endpackage

/* rtl/romaji_to_kana_converter.sv */
// Romaji-to-kana converter: one key in, one result out.
// Result valid in the cycle after input accept (output register).
// Throughput: one item per cycle; the table match is a single combinational pass.
// Input stalls only while a result is held by out_stall.
// Reset (rst, synchronous): roman mode on, history empty, output empty.
module romaji_to_kana_converter (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [8:0] key_code,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       matched,
  output logic [2:0] erase_count,
  output logic       prefix_n,
  output logic       prefix_small_tsu,
  output logic [8:0] kana_index
);
  logic mode, mode_next;
  r2k_pkg::hist_t hist, hist_next;
  r2k_pkg::result_t res_c, res;
  logic take;

  r2k_match u_match (.mode(mode), .hist(hist), .key(key_code),
    .mode_next(mode_next), .hist_next(hist_next), .res(res_c));

  assign in_stall = out_valid & out_stall;
  assign take = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b1;
      hist <= '0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        mode <= mode_next;
        hist <= hist_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
    if (take) res <= res_c;
  end

  assign matched = res.matched;
  assign erase_count = res.erase_count;
  assign prefix_n = res.prefix_n;
  assign prefix_small_tsu = res.prefix_small_tsu;
  assign kana_index = res.kana_index;
endmodule

/* rtl/r2k_match.sv */
// Match logic: decodes the key, shifts history, matches the table.
// Depends on r2k_pkg.
module r2k_match (
  input  logic            mode,
  input  r2k_pkg::hist_t  hist,
  input  logic [8:0]      key,
  output logic            mode_next,
  output r2k_pkg::hist_t  hist_next,
  output r2k_pkg::result_t res
);
  r2k_pkg::hist_t sh;
  logic [8:0] idx;
  logic hit, tsu, nf;
  logic [1:0] len;
  logic [3:0] k;
  r2k_pkg::char_t ha, hb, hc;

  always_comb begin
    sh = {hist[r2k_pkg::HISTORY_DEPTH-2:0], key[7:0]};
    mode_next = mode;
    hist_next = hist;
    res = '0;
    hit = 1'b0; len = 2'd0; idx = 9'd0; tsu = 1'b0; nf = 1'b0;
    ha = '0; hb = '0; hc = '0; k = '0;
    if (key == r2k_pkg::KEY_CLEAR) begin
      hist_next = '0;
    end else if (key == r2k_pkg::KEY_OFF) begin
      mode_next = 1'b0;
    end else if (key == r2k_pkg::KEY_TAB) begin
      mode_next = ~mode;
      hist_next = '0;
    end else if (!mode || key[8] || key[7:0] < 8'h20 || key[7:0] > 8'h7E) begin
      hist_next = '0;
    end else begin
      {hit, len, idx} = r2k_pkg::find_entry(sh);
      ha = (len != 2'd0) ? sh[3'(len) - 3'd1] : 8'd0;
      hb = sh[3'(len)];
      hc = (32'(len) + 1 < r2k_pkg::HISTORY_DEPTH) ? sh[3'(len) + 3'd1] : 8'd0;
      tsu = (ha == hb);
      nf = tsu ? (hc == r2k_pkg::CHAR_N) : (hb == r2k_pkg::CHAR_N);
      hist_next = sh;
      if (hit) begin
        k = 4'(len) + 4'(nf) + 4'(tsu);
        res.matched = 1'b1;
        res.erase_count = k[2:0];
        res.prefix_n = nf;
        res.prefix_small_tsu = tsu;
        res.kana_index = idx;
        hist_next = '0;
      end
    end
  end
endmodule

/* tb/tb_romaji_to_kana_converter.sv */
// Testbench for romaji_to_kana_converter: directed and random key items,
// checked against a behavioral predictor of the history/table match.
// Depends on rtl/r2k_pkg.sv, rtl/r2k_match.sv and rtl/romaji_to_kana_converter.sv.
`timescale 1ns / 1ps
module tb_romaji_to_kana_converter;

  localparam int NENT = r2k_pkg::TABLE_SIZE;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [8:0] key_code = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       matched;
  logic [2:0] erase_count;
  logic       prefix_n;
  logic       prefix_small_tsu;
  logic [8:0] kana_index;

  romaji_to_kana_converter u_top (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .key_code(key_code), .out_valid(out_valid), .out_stall(out_stall),
    .matched(matched), .erase_count(erase_count), .prefix_n(prefix_n),
    .prefix_small_tsu(prefix_small_tsu), .kana_index(kana_index)
  );

  initial forever #1 clk = ~clk;

  initial begin
    #400000;
    $display("FAIL romaji_to_kana_converter");
    $finish;
  end

  // Spelling table, newest key first, in priority order.
  logic [7:0]       spell [NENT][3];
  int               spell_len [NENT];
  logic             mode_on;
  logic [7:0]       keys [r2k_pkg::HISTORY_DEPTH+2];
  r2k_pkg::result_t expected_q [$];
  int               errors = 0;
  bit               gaps_on = 1'b1;
  bit               long_hold = 1'b0;

  task automatic add_entry(inout int n, input logic [7:0] a, b, c, input int len);
    spell[n][0] = a; spell[n][1] = b; spell[n][2] = c;
    spell_len[n] = len;
    n++;
  endtask

  task automatic build_table();
    string vw, ycons, hcons, c2a, c2b;
    int n;
    vw = "aiueo"; ycons = "bcdfghjkmnpqrstvxz"; hcons = "cdpstw";
    c2a = "bcdfghjklmn"; c2b = "pqrstvwxyz";
    n = 0;
    for (int c = 0; c < ycons.len(); c++)
      for (int v = 0; v < vw.len(); v++) add_entry(n, vw[v], "y", ycons[c], 3);
    for (int c = 0; c < hcons.len(); c++)
      for (int v = 0; v < vw.len(); v++) add_entry(n, vw[v], "h", hcons[c], 3);
    for (int v = 0; v < vw.len(); v++) add_entry(n, vw[v], "s", "t", 3);
    for (int c = 0; c < c2a.len(); c++)
      for (int v = 0; v < vw.len(); v++) add_entry(n, vw[v], c2a[c], 8'd0, 2);
    add_entry(n, "n", "n", 8'd0, 2);
    for (int c = 0; c < c2b.len(); c++)
      for (int v = 0; v < vw.len(); v++) add_entry(n, vw[v], c2b[c], 8'd0, 2);
    add_entry(n, "'", "n", 8'd0, 2);
    for (int v = 0; v < vw.len(); v++) add_entry(n, vw[v], 8'd0, 8'd0, 1);
    for (int ch = 8'h20; ch <= 8'h40; ch++) add_entry(n, 8'(ch), 8'd0, 8'd0, 1);
    for (int ch = 8'h5B; ch <= 8'h60; ch++) add_entry(n, 8'(ch), 8'd0, 8'd0, 1);
    for (int ch = 8'h7B; ch <= 8'h7E; ch++) add_entry(n, 8'(ch), 8'd0, 8'd0, 1);
  endtask

  function automatic logic [7:0] lower(input logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function automatic void clear_keys();
    foreach (keys[i]) keys[i] = '0;
  endfunction

  // Updates mode/history for one key and returns the expected result.
  function automatic r2k_pkg::result_t convert_key(input logic [8:0] k);
    r2k_pkg::result_t r;
    bit hit, tsu, nf;
    int len;
    r = '0;
    if (k == r2k_pkg::KEY_CLEAR) clear_keys();
    else if (k == r2k_pkg::KEY_OFF) mode_on = 1'b0;
    else if (k == r2k_pkg::KEY_TAB) begin
      mode_on = ~mode_on;
      clear_keys();
    end else if (!mode_on || k < 9'h020 || k > 9'h07E) clear_keys();
    else begin
      for (int i = r2k_pkg::HISTORY_DEPTH - 1; i > 0; i--) keys[i] = keys[i-1];
      keys[0] = k[7:0];
      for (int e = 0; e < NENT; e++) begin
        len = spell_len[e];
        hit = 1'b1;
        for (int j = 0; j < len; j++)
          if (lower(keys[j]) != lower(spell[e][j])) hit = 1'b0;
        if (hit) begin
          // entries past the history depth read as empty (kept zero)
          tsu = (keys[len-1] == keys[len]);
          nf = tsu ? (keys[len+1] == r2k_pkg::CHAR_N) : (keys[len] == r2k_pkg::CHAR_N);
          r.matched = 1'b1;
          r.erase_count = 3'(len + nf + tsu);
          r.prefix_n = nf;
          r.prefix_small_tsu = tsu;
          r.kana_index = 9'(e);
          clear_keys();
          break;
        end
      end
    end
    return r;
  endfunction

  task automatic send_key(input logic [8:0] k);
    in_valid <= 1'b1;
    key_code <= k;
    do @(posedge clk); while (in_stall);
    expected_q.push_back(convert_key(k));
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_key({1'b0, s[i]});
  endtask

  // Types one table spelling, oldest key first, with random case and prefixes.
  task automatic send_syllable();
    int e, len;
    logic [7:0] c;
    e = $urandom_range(0, 236);
    len = spell_len[e];
    if ($urandom_range(0, 3) == 0) send_key(9'(r2k_pkg::CHAR_N));
    if ($urandom_range(0, 3) == 0) send_key({1'b0, spell[e][len-1]});
    for (int j = len - 1; j >= 0; j--) begin
      c = spell[e][j];
      if (c >= "a" && c <= "z" && $urandom_range(0, 2) == 0) c = c - 8'd32;
      send_key({1'b0, c});
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      r2k_pkg::result_t got, want;
      got = {matched, erase_count, prefix_n, prefix_small_tsu, kana_index};
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (got.matched != want.matched || got.erase_count != want.erase_count ||
            got.prefix_n != want.prefix_n ||
            got.prefix_small_tsu != want.prefix_small_tsu ||
            got.kana_index != want.kana_index) begin
          $display("%0t: mismatch expected m=%0d e=%0d n=%0d t=%0d i=%0d",
                   $time, want.matched, want.erase_count, want.prefix_n,
                   want.prefix_small_tsu, want.kana_index);
          $display("%0t:          actual   m=%0d e=%0d n=%0d t=%0d i=%0d",
                   $time, got.matched, got.erase_count, got.prefix_n,
                   got.prefix_small_tsu, got.kana_index);
          errors++;
        end
      end
    end
  end

  // Output stall: random bursts, or a long hold on request.
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_stall <= 1'b1;
        for (n = 0; n < 150; n++) @(posedge clk);
        out_stall <= 1'b0;
        long_hold = 1'b0;
      end else if (gaps_on && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic test_special_keys();
    send_text("ka"); send_key(r2k_pkg::KEY_CLEAR); send_text("a");
    send_text("k"); send_key(r2k_pkg::KEY_OFF); send_text("ka");
    send_key(r2k_pkg::KEY_TAB); send_text("ka"); send_key(r2k_pkg::KEY_TAB);
    send_text("ka"); send_key(r2k_pkg::KEY_TAB);
    send_text("k"); send_key(9'h080); send_text("a");
    send_text("k"); send_key(9'h0FF); send_key(9'h1F); send_key(9'h07F);
    send_key(9'h100); send_key(9'h1FE); send_key(9'h07E); send_key(9'h020);
  endtask

  task automatic test_directed_romaji();
    send_text("kka"); send_text("nka"); send_text("nkka"); send_text("n'");
    send_text("nn"); send_text("KYA"); send_text("tsu"); send_text("aa");
    send_text("xqz"); send_text("Nka");
  endtask

  task automatic test_random_romaji(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) == 0) send_key(9'($urandom_range(0, 511)));
      else if ($urandom_range(0, 19) == 0)
        send_key($urandom_range(0, 1) ? r2k_pkg::KEY_TAB : r2k_pkg::KEY_OFF);
      else send_syllable();
    end
  endtask

  task automatic test_backpressure();
    long_hold = 1'b1;
    test_random_romaji(20);
    wait (!long_hold);
  endtask

  initial begin
    build_table();
    mode_on = 1'b1;
    clear_keys();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_special_keys();
    test_directed_romaji();
    test_random_romaji(90);
    test_backpressure();
    test_random_romaji(50);
    gaps_on = 1'b0;
    test_random_romaji(35);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) $display("PASS romaji_to_kana_converter");
    else $display("FAIL romaji_to_kana_converter");
    $finish;
  end
endmodule
